@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/vra_pkg.sv @@
// Shared constants, types and the CORDIC arctangent table for the axis rotator.
// No dependencies.
package vra_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int TRIG_STAGES = 16;
  localparam int AXIS_WIDTH  = 18;
  localparam int Q_FRAC      = 16;
  localparam int RND         = 1 << (Q_FRAC - 1);

  // CORDIC: three micro-rotations per register stage
  localparam int ITER_PER_STAGE = 3;
  localparam int CORDIC_PIPE    = (TRIG_STAGES + ITER_PER_STAGE - 1) / ITER_PER_STAGE;
  localparam int TRIG_LAT       = CORDIC_PIPE + 2;
  localparam int VEC_LAT        = 5;
  localparam int PT_DELAY       = TRIG_LAT - VEC_LAT;
  localparam int OUT_LAT        = TRIG_LAT + 2;

  // internal word widths, each wide enough for its worst case
  localparam int T_W    = COORD_WIDTH + 2;
  localparam int D_W    = COORD_WIDTH + 4;
  localparam int A_W    = COORD_WIDTH + 6;
  localparam int R_W    = COORD_WIDTH + 7;
  localparam int X_W    = COORD_WIDTH + 9;
  localparam int C_W    = COORD_WIDTH + 10;
  localparam int M_W    = C_W + 1;
  localparam int S_W    = C_W + 3;
  localparam int TRIG_W = 18;
  localparam int CD_W   = 34;

  localparam int ATAN_COUNT = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
  localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic        [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [TRIG_W-1:0]      trig_t;
  typedef logic signed [T_W-1:0]         tv_t;
  typedef logic signed [D_W-1:0]         dv_t;
  typedef logic signed [A_W-1:0]         av_t;
  typedef logic signed [R_W-1:0]         rv_t;
  typedef logic signed [X_W-1:0]         xv_t;
  typedef logic signed [C_W-1:0]         cv_t;
  typedef logic signed [M_W-1:0]         mv_t;
  typedef logic signed [S_W-1:0]         sv_t;
  typedef logic signed [CD_W-1:0]        cd_t;

  typedef struct packed {
    logic             vld;
    coord_t [2:0]     p;
    axis_t  [2:0]     k;
  } vin_t;

  typedef struct packed {
    logic             vld;
    rv_t    [2:0]     r;
    cv_t    [2:0]     c;
    av_t    [2:0]     a;
  } vres_t;

  typedef struct packed {
    logic             vld;
    trig_t            sn;
    trig_t            cs;
  } trig_res_t;

endpackage

@@ hdl/vra_cordic.sv @@
// Pipelined CORDIC giving sine and cosine of a binary angle, Q.16, clamped.
// Depends on vra_pkg.
module vra_cordic import vra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  angle_t    angle,
  output trig_res_t trig
);

  logic [CORDIC_PIPE:0] vld_r;
  logic [CORDIC_PIPE:0] neg_r;
  cd_t x_r [CORDIC_PIPE+1];
  cd_t y_r [CORDIC_PIPE+1];
  cd_t z_r [CORDIC_PIPE+1];
  cd_t x_nxt [CORDIC_PIPE];
  cd_t y_nxt [CORDIC_PIPE];
  cd_t z_nxt [CORDIC_PIPE];

  logic        out_vld_r;
  trig_t       sn_r, cs_r;
  trig_t       sn_nxt, cs_nxt;

  logic [31:0] a32;
  logic        fold;
  logic [31:0] zf;

  function automatic trig_t to_q16(input cd_t v);
    cd_t t;
    t = (v + cd_t'(8192)) >>> 14;
    if (t > cd_t'(65536)) return trig_t'(65536);
    if (t < cd_t'(-65536)) return trig_t'(-65536);
    return trig_t'(t);
  endfunction

  // fold into the right half-plane by a half turn
  always_comb begin
    a32  = {angle, {(32-ANGLE_WIDTH){1'b0}}};
    fold = (a32 > 32'h4000_0000) && (a32 < 32'hC000_0000);
    zf   = fold ? (a32 - 32'h8000_0000) : a32;
  end

  for (genvar s = 0; s < CORDIC_PIPE; s++) begin : g_it
    always_comb begin
      cd_t x, y, z, dx, dy;
      int  i;
      x = x_r[s];
      y = y_r[s];
      z = z_r[s];
      for (int j = 0; j < ITER_PER_STAGE; j++) begin
        i = s * ITER_PER_STAGE + j;
        if (i < TRIG_STAGES && i < ATAN_COUNT) begin
          dx = y >>> i;
          dy = x >>> i;
          if (!z[CD_W-1]) begin
            x = x - dx;
            y = y + dy;
            z = z - cd_t'(ATAN_TAB[i]);
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + cd_t'(ATAN_TAB[i]);
          end
        end
      end
      x_nxt[s] = x;
      y_nxt[s] = y;
      z_nxt[s] = z;
    end
  end

  always_comb begin
    cs_nxt = to_q16(neg_r[CORDIC_PIPE] ? -x_r[CORDIC_PIPE] : x_r[CORDIC_PIPE]);
    sn_nxt = to_q16(neg_r[CORDIC_PIPE] ? -y_r[CORDIC_PIPE] : y_r[CORDIC_PIPE]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[CORDIC_PIPE-1:0], in_vld};
      out_vld_r <= vld_r[CORDIC_PIPE];
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= cd_t'(CORDIC_GAIN);
    y_r[0]   <= '0;
    z_r[0]   <= cd_t'($signed(zf));
    neg_r[0] <= fold;
    for (int s = 0; s < CORDIC_PIPE; s++) begin
      x_r[s+1]   <= x_nxt[s];
      y_r[s+1]   <= y_nxt[s];
      z_r[s+1]   <= z_nxt[s];
      neg_r[s+1] <= neg_r[s];
    end
    sn_r <= sn_nxt;
    cs_r <= cs_nxt;
  end

  assign trig = '{vld: out_vld_r, sn: sn_r, cs: cs_r};

endmodule

@@ hdl/vra_vec.sv @@
// Vector front end: axial projection, radial part and radial-cross-axis terms.
// Depends on vra_pkg.
module vra_vec import vra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  vin_t  vin,
  output vres_t vres
);

  logic [4:0] vld_r;

  // stage 1: dot-product terms
  tv_t    t1_r [3];
  coord_t p1_r [3];
  axis_t  k1_r [3];
  tv_t    t1_nxt [3];
  // stage 2: dot product
  dv_t    d2_r;
  coord_t p2_r [3];
  axis_t  k2_r [3];
  // stage 3: axial and radial parts
  av_t    a3_r [3];
  rv_t    r3_r [3];
  axis_t  k3_r [3];
  av_t    a3_nxt [3];
  rv_t    r3_nxt [3];
  // stage 4: cross terms
  xv_t    xa4_r [3];
  xv_t    xb4_r [3];
  av_t    a4_r [3];
  rv_t    r4_r [3];
  xv_t    xa4_nxt [3];
  xv_t    xb4_nxt [3];
  // stage 5: cross product
  cv_t    c5_r [3];
  av_t    a5_r [3];
  rv_t    r5_r [3];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    localparam int J1 = (j + 1) % 3;
    localparam int J2 = (j + 2) % 3;

    always_comb begin
      logic signed [COORD_WIDTH+AXIS_WIDTH-1:0] pr;
      pr = $signed(vin.p[j]) * $signed(vin.k[j]);
      pr = pr + RND;
      t1_nxt[j] = tv_t'(pr >>> Q_FRAC);
    end

    always_comb begin
      logic signed [D_W+AXIS_WIDTH-1:0] pr;
      pr = d2_r * k2_r[j];
      pr = pr + RND;
      a3_nxt[j] = av_t'(pr >>> Q_FRAC);
      r3_nxt[j] = rv_t'(p2_r[j]) - rv_t'(a3_nxt[j]);
    end

    always_comb begin
      logic signed [R_W+AXIS_WIDTH-1:0] pa, pb;
      pa = r3_r[J1] * k3_r[J2];
      pb = r3_r[J2] * k3_r[J1];
      pa = pa + RND;
      pb = pb + RND;
      xa4_nxt[j] = xv_t'(pa >>> Q_FRAC);
      xb4_nxt[j] = xv_t'(pb >>> Q_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], vin.vld};
    end
  end

  always_ff @(posedge clk) begin
    d2_r <= dv_t'(t1_r[0]) + dv_t'(t1_r[1]) + dv_t'(t1_r[2]);
    for (int j = 0; j < 3; j++) begin
      t1_r[j]  <= t1_nxt[j];
      p1_r[j]  <= vin.p[j];
      k1_r[j]  <= vin.k[j];
      p2_r[j]  <= p1_r[j];
      k2_r[j]  <= k1_r[j];
      a3_r[j]  <= a3_nxt[j];
      r3_r[j]  <= r3_nxt[j];
      k3_r[j]  <= k2_r[j];
      xa4_r[j] <= xa4_nxt[j];
      xb4_r[j] <= xb4_nxt[j];
      a4_r[j]  <= a3_r[j];
      r4_r[j]  <= r3_r[j];
      c5_r[j]  <= cv_t'(xa4_r[j]) - cv_t'(xb4_r[j]);
      a5_r[j]  <= a4_r[j];
      r5_r[j]  <= r4_r[j];
    end
  end

  always_comb begin
    vres.vld = vld_r[4];
    for (int j = 0; j < 3; j++) begin
      vres.r[j] = r5_r[j];
      vres.c[j] = c5_r[j];
      vres.a[j] = a5_r[j];
    end
  end

endmodule

@@ hdl/vra_comb.sv @@
// Back end: scales radial and cross parts by cosine and sine, adds the axial
// part and saturates. Depends on vra_pkg.
module vra_comb import vra_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  vres_t        vres,
  input  trig_res_t    trig,
  output logic         out_vld,
  output coord_t [2:0] rot
);

  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic   vld6_r, vld7_r;
  mv_t    m6_r [3];
  mv_t    n6_r [3];
  av_t    a6_r [3];
  mv_t    m6_nxt [3];
  mv_t    n6_nxt [3];
  coord_t o7_r [3];
  coord_t o7_nxt [3];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    always_comb begin
      logic signed [R_W+TRIG_W-1:0] pm;
      logic signed [C_W+TRIG_W-1:0] pn;
      pm = $signed(vres.r[j]) * trig.cs;
      pn = $signed(vres.c[j]) * trig.sn;
      pm = pm + RND;
      pn = pn + RND;
      m6_nxt[j] = mv_t'(pm >>> Q_FRAC);
      n6_nxt[j] = mv_t'(pn >>> Q_FRAC);
    end

    always_comb begin
      sv_t s;
      s = sv_t'(m6_r[j]) + sv_t'(n6_r[j]) + sv_t'(a6_r[j]);
      if ((&s[S_W-1:COORD_WIDTH-1]) || !(|s[S_W-1:COORD_WIDTH-1])) begin
        o7_nxt[j] = s[COORD_WIDTH-1:0];
      end else begin
        o7_nxt[j] = s[S_W-1] ? C_MIN : C_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld6_r <= vres.vld;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      m6_r[j] <= m6_nxt[j];
      n6_r[j] <= n6_nxt[j];
      a6_r[j] <= vres.a[j];
      o7_r[j] <= o7_nxt[j];
    end
  end

  assign out_vld = vld7_r;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rot[j] = o7_r[j];
    end
  end

endmodule

@@ hdl/vector_rotate_about_axis.sv @@
// Rotation of a Q16.16 point about a Q1.16 unit axis by a binary angle.
// Depends on vra_pkg, vra_cordic, vra_vec, vra_comb and assert_macros.svh.
//
// Usage
//   Request channel: drive the point, axis and angle on the in_ ports and
//   pulse start. busy is held low, so a request is taken on every edge at
//   which start is high: one point per clock, back to back.
//   Result channel: out_valid is high for exactly one cycle with the
//   rotated point on out_rotated_x/y/z. The receiver cannot hold results
//   off and none is ever needed: the pipeline never stalls.
//   Pipeline: the request-to-result path is set by the CORDIC, which does
//   three micro-rotations per register stage plus a fold stage and a
//   rounding stage; the vector path (dot product, radial part, cross
//   product) is delayed to meet it, then two stages scale, sum and
//   saturate.
//   Throughput: one request per cycle, results in request order.
//   Reset: rst_n low empties the pipeline; requests in flight are dropped
//   and no result appears until new requests reach the end.
//   Positive angles turn counterclockwise seen looking along +axis. The axis is
//   not normalised; results saturate to the coordinate range.
`include "assert_macros.svh"

module vector_rotate_about_axis import vra_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  coord_t in_point_x,
  input  coord_t in_point_y,
  input  coord_t in_point_z,
  input  axis_t  in_axis_x,
  input  axis_t  in_axis_y,
  input  axis_t  in_axis_z,
  input  angle_t in_turn_angle,
  output logic   out_valid,
  output coord_t out_rotated_x,
  output coord_t out_rotated_y,
  output coord_t out_rotated_z
);

  vin_t         vin_now;
  vin_t         vin_dly;
  vres_t        vres;
  trig_res_t    trig;
  coord_t [2:0] rot;

  // never back-pressures: every stage moves on every clock
  assign busy = 1'b0;

  always_comb begin
    vin_now.vld  = start;
    vin_now.p[0] = in_point_x;
    vin_now.p[1] = in_point_y;
    vin_now.p[2] = in_point_z;
    vin_now.k[0] = in_axis_x;
    vin_now.k[1] = in_axis_y;
    vin_now.k[2] = in_axis_z;
  end

  // align the vector path with the trig pipeline
  if (PT_DELAY > 0) begin : g_dly
    logic [PT_DELAY-1:0] dvld_r;
    vin_t                dly_r [PT_DELAY];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r <= '0;
      end else begin
        dvld_r[0] <= start;
        for (int i = 1; i < PT_DELAY; i++) begin
          dvld_r[i] <= dvld_r[i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      dly_r[0] <= vin_now;
      for (int i = 1; i < PT_DELAY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end

    always_comb begin
      vin_dly     = dly_r[PT_DELAY-1];
      vin_dly.vld = dvld_r[PT_DELAY-1];
    end
  end else begin : g_nodly
    assign vin_dly = vin_now;
  end

  vra_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start),
    .angle  (in_turn_angle),
    .trig   (trig)
  );

  vra_vec u_vec (
    .clk   (clk),
    .rst_n (rst_n),
    .vin   (vin_dly),
    .vres  (vres)
  );

  vra_comb u_comb (
    .clk     (clk),
    .rst_n   (rst_n),
    .vres    (vres),
    .trig    (trig),
    .out_vld (out_valid),
    .rot     (rot)
  );

  assign out_rotated_x = rot[0];
  assign out_rotated_y = rot[1];
  assign out_rotated_z = rot[2];

  // the two paths must meet in the same cycle
  `ASSERT_IMP(a_align_vec, clk, rst_n, vres.vld, trig.vld)
  `ASSERT_IMP(a_align_trig, clk, rst_n, trig.vld, vres.vld)
  // every result traces back to a request a fixed latency earlier
  `ASSERT_IMP(a_latency, clk, rst_n, out_valid, $past(start, OUT_LAT))
  `ASSERT_NXT(a_out_follows, clk, rst_n, vres.vld, ##1 out_valid)

endmodule

@@ tb/sv/vra_checker.sv @@
// Scoreboard for the axis rotator: watches requests and results, predicts each
// rotated point and compares. Depends on vra_pkg.
module vra_checker import vra_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   busy,
  input  coord_t in_point_x,
  input  coord_t in_point_y,
  input  coord_t in_point_z,
  input  axis_t  in_axis_x,
  input  axis_t  in_axis_y,
  input  axis_t  in_axis_z,
  input  angle_t in_turn_angle,
  input  logic   out_valid,
  input  coord_t out_rotated_x,
  input  coord_t out_rotated_y,
  input  coord_t out_rotated_z,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  point_t rotated_q[$];

  // round(a*b/2^16), half up
  function automatic longint mul_q16(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  function automatic void sin_cos(angle_t ang, output longint sn, output longint cs);
    logic [31:0] a32;
    logic neg;
    longint x, y, z, dx, dy;
    a32 = {ang, {(32-ANGLE_WIDTH){1'b0}}};
    neg = 1'b0;
    x = longint'(CORDIC_GAIN);
    y = 0;
    if (a32 > 32'h40000000 && a32 < 32'hC0000000) begin
      a32 = a32 - 32'h80000000;
      neg = 1'b1;
    end
    z = longint'($signed(a32));
    for (int i = 0; i < TRIG_STAGES && i < ATAN_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    cs = clamp_unit(x);
    sn = clamp_unit(y);
  endfunction

  function automatic point_t rotate_point(coord_t px, coord_t py, coord_t pz,
                                          axis_t kx, axis_t ky, axis_t kz, angle_t ang);
    longint p[3], k[3], r[3], c[3], d, sn, cs, v, mx, mn;
    coord_t o[3];
    point_t res;
    p[0] = px; p[1] = py; p[2] = pz;
    k[0] = kx; k[1] = ky; k[2] = kz;
    mx = (64'sd1 <<< (COORD_WIDTH-1)) - 1;
    mn = -mx - 1;
    sin_cos(ang, sn, cs);
    d = mul_q16(p[0], k[0]) + mul_q16(p[1], k[1]) + mul_q16(p[2], k[2]);
    for (int j = 0; j < 3; j++) r[j] = p[j] - mul_q16(d, k[j]);
    c[0] = mul_q16(r[1], k[2]) - mul_q16(r[2], k[1]);
    c[1] = mul_q16(r[2], k[0]) - mul_q16(r[0], k[2]);
    c[2] = mul_q16(r[0], k[1]) - mul_q16(r[1], k[0]);
    for (int j = 0; j < 3; j++) begin
      v = mul_q16(r[j], cs) + mul_q16(c[j], sn) + mul_q16(d, k[j]);
      if (v > mx) v = mx;
      if (v < mn) v = mn;
      o[j] = coord_t'(v);
    end
    res.x = o[0]; res.y = o[1]; res.z = o[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, coord_t got, coord_t want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      if (start && !busy)
        rotated_q.push_back(rotate_point(in_point_x, in_point_y, in_point_z,
                                         in_axis_x, in_axis_y, in_axis_z, in_turn_angle));
      if (out_valid) begin
        if (rotated_q.size() == 0) begin
          $display("%0t result with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = rotated_q.pop_front();
          if (out_rotated_x !== want.x) report_mismatch("x", out_rotated_x, want.x);
          if (out_rotated_y !== want.y) report_mismatch("y", out_rotated_y, want.y);
          if (out_rotated_z !== want.z) report_mismatch("z", out_rotated_z, want.z);
        end
      end
    end
    pending = rotated_q.size();
  end
endmodule

@@ tb/sv/tb_vector_rotate_about_axis.sv @@
// Top of the axis rotator testbench: clock, reset, request stimulus, verdict.
// Depends on vra_pkg, vector_rotate_about_axis and vra_checker.
module tb_vector_rotate_about_axis;
  import vra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 1550;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_point_x = '0, in_point_y = '0, in_point_z = '0;
  axis_t  in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  angle_t in_turn_angle = '0;
  logic   out_valid;
  coord_t out_rotated_x, out_rotated_y, out_rotated_z;
  int     fail_count, pending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vector_rotate_about_axis dut (.*);
  vra_checker u_checker (.*);

  // Present one request and hold it until taken. start stays high between
  // back-to-back requests; it is only dropped by an idle cycle or at the end of the stimulus.
  task automatic send_request(coord_t px, coord_t py, coord_t pz,
                              axis_t kx, axis_t ky, axis_t kz, angle_t ang);
    start         <= 1'b1;
    in_point_x    <= px;
    in_point_y    <= py;
    in_point_z    <= pz;
    in_axis_x     <= kx;
    in_axis_y     <= ky;
    in_axis_z     <= kz;
    in_turn_angle <= ang;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // unit axis along a random principal direction, or random raw components
  function automatic axis_t unit_or_raw(int sel);
    case (sel)
      0: return axis_t'(65536);
      1: return axis_t'(-65536);
      2: return '0;
      default: return axis_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
      2: return $urandom_range(0, 1) ? coord_t'(32'h7FFFFFFF) : coord_t'(32'h80000000);
      default: return coord_t'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF);
    endcase
  endfunction

  initial begin
    axis_t kx, ky, kz;
    int    sel;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: quadrant angles, axis extremes, coordinate extremes
    send_request(32'sh00010000, 0, 0, 0, 0, axis_t'(65536), 16'h0000);
    send_request(32'sh00010000, 0, 0, 0, 0, axis_t'(65536), 16'h4000);
    send_request(32'sh00010000, 0, 0, 0, 0, axis_t'(65536), 16'h8000);
    send_request(32'sh00010000, 0, 0, 0, 0, axis_t'(65536), 16'hC000);
    send_request(32'sh00010000, 32'sh00020000, 0, 0, 0, axis_t'(-65536), 16'h4001);
    send_request(0, 32'sh00030000, 32'sh00010000, axis_t'(65536), 0, 0, 16'hBFFF);
    send_request(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 axis_t'(18'h1FFFF), axis_t'(18'h1FFFF), axis_t'(18'h1FFFF), 16'h2000);
    send_request(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 axis_t'(18'h20000), axis_t'(18'h20000), axis_t'(18'h20000), 16'hFFFF);
    send_request(32'sh7FFFFFFF, 32'sh80000000, 0,
                 axis_t'(18'h20000), axis_t'(18'h1FFFF), 0, 16'h6000);
    send_request(0, 0, 0, 0, 0, 0, 16'h1234);
    // non-unit axis with a scaled result, then a unit diagonal axis and the unit y axis
    send_request(32'sh00050000, 32'sh00010000, 32'shFFFF0000,
                 axis_t'(46341), axis_t'(46341), axis_t'(46341), 16'h2AAA);
    send_request(32'sh12345678, 32'shEDCBA987, 32'sh0F0F0F0F,
                 axis_t'(37837), axis_t'(-37837), axis_t'(37837), 16'h8001);
    send_request(32'sh00010000, 32'sh00010000, 32'sh00010000,
                 0, axis_t'(65536), 0, 16'h7FFF);
    idle_cycle();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      // no idling through a long stretch in the middle
      if (!(i >= 600 && i < 900))
        while ($urandom_range(0, 99) < 27) idle_cycle();
      sel = $urandom_range(0, 5);
      kx = unit_or_raw(sel == 0 ? $urandom_range(0, 2) : 3);
      ky = unit_or_raw(sel == 1 ? $urandom_range(0, 2) : 3);
      kz = unit_or_raw(sel == 2 ? $urandom_range(0, 2) : 3);
      if (sel < 3) begin
        if (sel != 0) kx = '0;
        if (sel != 1) ky = '0;
        if (sel != 2) kz = '0;
      end
      send_request(rand_coord(), rand_coord(), rand_coord(), kx, ky, kz,
                   angle_t'($urandom));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (OUT_LAT + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/vra_pkg.sv
hdl/vra_cordic.sv
hdl/vra_vec.sv
hdl/vra_comb.sv
hdl/vector_rotate_about_axis.sv
tb/sv/vra_checker.sv
tb/sv/tb_vector_rotate_about_axis.sv
